@@ design/dhbd_pkg.sv @@
// dhbd_pkg: shared types, constants and tables of the detection head box decoder
// no dependencies; used by dhbd_front, dhbd_back and detection_head_box_decode
`timescale 1ns / 1ps
`default_nettype none

package dhbd_pkg;

	localparam int MAX_CLASSES       = 64;
	localparam int ANCHORS_PER_SCALE = 3;
	localparam int IMAGE_SIZE        = 512;

	// width of the doubled centre and corner terms in Q32
	localparam int DIFF_W = 49;
	// width of the offset centre term in Q16
	localparam int UX_W   = 24;
	// width of the size terms in Q32
	localparam int SZ_W   = 44;

	// configuration register indexes
	localparam logic [7:0] REG_NUM_CLASSES      = 8'd0;
	localparam logic [7:0] REG_THRESHOLD_FINE   = 8'd1;
	localparam logic [7:0] REG_THRESHOLD_MID    = 8'd2;
	localparam logic [7:0] REG_THRESHOLD_COARSE = 8'd3;

	localparam logic [6:0]  RST_NUM_CLASSES      = 7'd36;
	localparam logic [15:0] RST_THRESHOLD_FINE   = 16'd36045;
	localparam logic [15:0] RST_THRESHOLD_MID    = 16'd29491;
	localparam logic [15:0] RST_THRESHOLD_COARSE = 16'd26214;

	localparam logic [1:0] SCALE_FINE   = 2'd0;
	localparam logic [1:0] SCALE_MID    = 2'd1;
	localparam logic [1:0] SCALE_COARSE = 2'd2;

	// sigmoid(i/16) in Q0.16 for i = 0..128
	typedef logic [128:0][15:0] sig_tab_t;

	typedef struct packed {
		logic [15:0] sig_x;
		logic [15:0] sig_y;
		logic [15:0] sig_w;
		logic [15:0] sig_h;
		logic [15:0] obj_prob;
		logic [15:0] best_prob;
		logic [5:0]  class_id;
		logic [1:0]  scale;
		logic [1:0]  anchor_slot;
		logic [5:0]  grid_row;
		logic [5:0]  grid_col;
	} cell_rec_t;

	typedef struct packed {
		logic signed [11:0] box_left;
		logic signed [11:0] box_top;
		logic [10:0]        box_width;
		logic [10:0]        box_height;
		logic [15:0]        confidence;
		logic [5:0]         class_id;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_SCALE,
		BK_DIFF,
		BK_EMIT
	} back_state_t;

	// elaboration only: e steps down by exp(-1/16), entry is round(2^48 / (2^32 + e))
	function automatic sig_tab_t build_sig_tab();
		sig_tab_t    tab;
		logic [95:0] e;
		logic [33:0] d;
		logic [49:0] num;
		logic [49:0] quo;
		logic [34:0] rem;
		tab = '0;
		e = 96'd1 << 32;
		for (int i = 0; i <= 128; i++) begin
			d = 34'(e) + (34'd1 << 32);
			num = (50'd1 << 48) + 50'(d >> 1);
			rem = '0;
			quo = '0;
			for (int b = 49; b >= 0; b--) begin
				rem = {rem[33:0], num[b]};
				if (rem >= 35'(d)) begin
					rem = rem - 35'(d);
					quo[b] = 1'b1;
				end
			end
			tab[i] = quo[15:0];
			e = ((e * 96'd4034748382) + (96'd1 << 31)) >> 32;
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

	function automatic logic [8:0] anchor_w(input logic [1:0] sc, input logic [1:0] sl);
		logic [8:0] v;
		unique case ({sc, sl})
			4'b00_00: v = 9'd10;
			4'b00_01: v = 9'd13;
			4'b00_10: v = 9'd18;
			4'b01_00: v = 9'd20;
			4'b01_01: v = 9'd29;
			4'b01_10: v = 9'd42;
			4'b10_00: v = 9'd64;
			4'b10_01: v = 9'd139;
			4'b10_10: v = 9'd309;
			default:  v = 9'd0;
		endcase
		return v;
	endfunction

	function automatic logic [8:0] anchor_h(input logic [1:0] sc, input logic [1:0] sl);
		logic [8:0] v;
		unique case ({sc, sl})
			4'b00_00: v = 9'd15;
			4'b00_01: v = 9'd24;
			4'b00_10: v = 9'd19;
			4'b01_00: v = 9'd44;
			4'b01_01: v = 9'd26;
			4'b01_10: v = 9'd43;
			4'b10_00: v = 9'd115;
			4'b10_01: v = 9'd111;
			4'b10_10: v = 9'd379;
			default:  v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ design/dhbd_fifo.sv @@
// dhbd_fifo: two-entry register queue with full and empty flags
// no package dependency; instanced for the cell queue and the result queue
`timescale 1ns / 1ps
`default_nettype none

module dhbd_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ design/dhbd_front.sv @@
// dhbd_front: takes logit beats, runs the sigmoid pipeline and the running argmax, and hands
// each finished cell with at least one class beat and a valid scale and slot to the cell queue; depends on dhbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dhbd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic signed [15:0] logit,
	input  wire logic [1:0]        scale,
	input  wire logic [1:0]        anchor_slot,
	input  wire logic [5:0]        grid_row,
	input  wire logic [5:0]        grid_col,
	input  wire logic              last,
	input  wire logic [6:0]        num_classes,
	input  wire logic              cq_full,
	output logic                   cq_push,
	output dhbd_pkg::cell_rec_t    cq_rec
);

	// stage 1: magnitude split into table index and fraction
	logic       valid_s1;
	logic       neg_s1;
	logic [7:0] k_s1;
	logic [3:0] f_s1;
	logic       last_s1;
	logic [1:0] scale_s1;
	logic [1:0] slot_s1;
	logic [5:0] row_s1;
	logic [5:0] col_s1;

	// stage 2: sigmoid value
	logic        valid_s2;
	logic [15:0] sig_s2;
	logic        last_s2;
	logic [1:0]  scale_s2;
	logic [1:0]  slot_s2;
	logic [5:0]  row_s2;
	logic [5:0]  col_s2;

	// cell state
	logic [6:0]  pos_q;
	logic [15:0] box_q [4];
	logic [15:0] obj_q;
	logic [15:0] best_q;
	logic [5:0]  idx_q;

	logic        adv;
	logic        accept;
	logic [15:0] mag;
	logic [7:0]  k_hi;
	logic [15:0] t_lo;
	logic [15:0] t_hi;
	logic [19:0] interp;
	logic [16:0] p_sum;
	logic [15:0] sig_val;
	logic [6:0]  limit;
	logic [6:0]  class_pos;
	logic        take_class;
	logic [15:0] best_next;
	logic [5:0]  idx_next;
	logic        keep;

	// the pipe only stops while a finished cell waits for room in the queue
	assign adv    = !(valid_s2 && last_s2 && cq_full);
	assign full   = !adv;
	assign accept = push && adv;

	assign mag = logit[15] ? 16'(-logit) : logit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1   <= logit[15];
			last_s1  <= last;
			scale_s1 <= scale;
			slot_s1  <= anchor_slot;
			row_s1   <= grid_row;
			col_s1   <= grid_col;
			if (mag >= 16'd2048) begin
				k_s1 <= 8'd128;
				f_s1 <= 4'd0;
			end else begin
				k_s1 <= {1'b0, mag[10:4]};
				f_s1 <= mag[3:0];
			end
		end
	end

	// linear interpolation between neighbouring table entries
	always_comb begin
		k_hi    = (k_s1 == 8'd128) ? 8'd128 : k_s1 + 8'd1;
		t_lo    = dhbd_pkg::SIG_TAB[k_s1];
		t_hi    = dhbd_pkg::SIG_TAB[k_hi];
		interp  = 20'(t_hi - t_lo) * 20'(f_s1) + 20'd8;
		p_sum   = 17'(t_lo) + 17'(interp[19:4]);
		sig_val = neg_s1 ? 16'(17'h10000 - p_sum) : p_sum[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sig_s2   <= sig_val;
			last_s2  <= last_s1;
			scale_s2 <= scale_s1;
			slot_s2  <= slot_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
		end
	end

	// first-wins argmax over the classes inside the limit
	always_comb begin
		limit      = (num_classes > 7'(dhbd_pkg::MAX_CLASSES)) ?
			7'(dhbd_pkg::MAX_CLASSES) : num_classes;
		class_pos  = pos_q - 7'd5;
		take_class = (pos_q >= 7'd5) && (class_pos < limit) && (sig_s2 > best_q);
		best_next  = take_class ? sig_s2 : best_q;
		idx_next   = take_class ? class_pos[5:0] : idx_q;
		keep       = (pos_q >= 7'd5) && (scale_s2 <= dhbd_pkg::SCALE_COARSE) &&
			(32'(slot_s2) < 32'(dhbd_pkg::ANCHORS_PER_SCALE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 7'd0;
			best_q <= 16'd0;
			idx_q  <= 6'd0;
		end else if (adv && valid_s2) begin
			if (last_s2) begin
				pos_q  <= 7'd0;
				best_q <= 16'd0;
				idx_q  <= 6'd0;
			end else begin
				if (pos_q != 7'd127) begin
					pos_q <= pos_q + 7'd1;
				end
				best_q <= best_next;
				idx_q  <= idx_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			if (pos_q < 7'd4) begin
				box_q[pos_q[1:0]] <= sig_s2;
			end
			if (pos_q == 7'd4) begin
				obj_q <= sig_s2;
			end
		end
	end

	assign cq_push = adv && valid_s2 && last_s2 && keep;

	always_comb begin
		cq_rec.sig_x       = box_q[0];
		cq_rec.sig_y       = box_q[1];
		cq_rec.sig_w       = box_q[2];
		cq_rec.sig_h       = box_q[3];
		cq_rec.obj_prob    = obj_q;
		cq_rec.best_prob   = best_next;
		cq_rec.class_id    = idx_next;
		cq_rec.scale       = scale_s2;
		cq_rec.anchor_slot = slot_s2;
		cq_rec.grid_row    = row_s2;
		cq_rec.grid_col    = col_s2;
	end

endmodule

`default_nettype wire

@@ design/dhbd_back.sv @@
// dhbd_back: per-cell sequencer for confidence, threshold test and box decode
// depends on dhbd_pkg; reads the cell queue and writes the result queue
`timescale 1ns / 1ps
`default_nettype none

module dhbd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cq_empty,
	input  wire dhbd_pkg::cell_rec_t cq_rec,
	output logic                     cq_pop,
	input  wire logic [15:0]         threshold_fine,
	input  wire logic [15:0]         threshold_mid,
	input  wire logic [15:0]         threshold_coarse,
	input  wire logic                rq_full,
	output logic                     rq_push,
	output dhbd_pkg::res_t           rq_res
);

	localparam int DW = dhbd_pkg::DIFF_W;
	localparam int RW = DW - 33;
	localparam logic signed [DW-1:0] HALF_Q33 = DW'(64'h1_0000_0000);
	localparam logic signed [RW-1:0] CORNER_HI = RW'(2047);
	localparam logic signed [RW-1:0] CORNER_LO = RW'(-2048);

	dhbd_pkg::back_state_t state_q;
	dhbd_pkg::back_state_t state_d;

	dhbd_pkg::cell_rec_t        rec_q;
	logic [31:0]                prod_q;
	logic [31:0]                sqw_q;
	logic [31:0]                sqh_q;
	logic signed [dhbd_pkg::UX_W-1:0] ux_q;
	logic signed [dhbd_pkg::UX_W-1:0] uy_q;
	logic [15:0]                conf_q;
	logic [dhbd_pkg::SZ_W-1:0]  w_q;
	logic [dhbd_pkg::SZ_W-1:0]  h_q;
	logic signed [DW-1:0]       cx2_q;
	logic signed [DW-1:0]       cy2_q;
	logic signed [DW-1:0]       dl_q;
	logic signed [DW-1:0]       dt_q;
	logic [10:0]                wr_q;
	logic [10:0]                hr_q;
	logic                       pass_q;

	logic [15:0]                thr;
	logic [dhbd_pkg::SZ_W:0]    w_round;
	logic [dhbd_pkg::SZ_W:0]    h_round;

	// half away from zero at 2^-33, then clamp to the 12-bit corner range
	function automatic logic signed [11:0] round_corner(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] biased;
		logic signed [RW-1:0] r;
		logic signed [11:0]   o;
		biased = v + HALF_Q33 - DW'(v[DW-1]);
		r = $signed(biased[DW-1:33]);
		if (r > CORNER_HI) begin
			o = 12'sd2047;
		end else if (r < CORNER_LO) begin
			o = -12'sd2048;
		end else begin
			o = r[11:0];
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhbd_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cq_pop  = 1'b0;
		rq_push = 1'b0;
		unique case (state_q)
			dhbd_pkg::BK_IDLE: begin
				if (!cq_empty) begin
					cq_pop  = 1'b1;
					state_d = dhbd_pkg::BK_MUL;
				end
			end
			dhbd_pkg::BK_MUL:   state_d = dhbd_pkg::BK_SCALE;
			dhbd_pkg::BK_SCALE: state_d = dhbd_pkg::BK_DIFF;
			dhbd_pkg::BK_DIFF:  state_d = dhbd_pkg::BK_EMIT;
			dhbd_pkg::BK_EMIT: begin
				if (!pass_q) begin
					state_d = dhbd_pkg::BK_IDLE;
				end else if (!rq_full) begin
					rq_push = 1'b1;
					state_d = dhbd_pkg::BK_IDLE;
				end
			end
			default: state_d = dhbd_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		case (rec_q.scale)
			dhbd_pkg::SCALE_FINE: thr = threshold_fine;
			dhbd_pkg::SCALE_MID:  thr = threshold_mid;
			default:              thr = threshold_coarse;
		endcase
		w_round = (dhbd_pkg::SZ_W + 1)'(w_q) + (dhbd_pkg::SZ_W + 1)'(33'h0_8000_0000);
		h_round = (dhbd_pkg::SZ_W + 1)'(h_q) + (dhbd_pkg::SZ_W + 1)'(33'h0_8000_0000);
	end

	always_ff @(posedge clk) begin
		if (cq_pop) begin
			rec_q <= cq_rec;
		end
		if (state_q == dhbd_pkg::BK_MUL) begin
			prod_q <= 32'(rec_q.obj_prob) * 32'(rec_q.best_prob);
			sqw_q  <= 32'(rec_q.sig_w) * 32'(rec_q.sig_w);
			sqh_q  <= 32'(rec_q.sig_h) * 32'(rec_q.sig_h);
			// 2*s - 0.5 + cell index, in Q16
			ux_q   <= $signed({2'b0, rec_q.grid_col, 16'b0}) +
				$signed({7'b0, rec_q.sig_x, 1'b0}) - 24'sd32768;
			uy_q   <= $signed({2'b0, rec_q.grid_row, 16'b0}) +
				$signed({7'b0, rec_q.sig_y, 1'b0}) - 24'sd32768;
		end
		if (state_q == dhbd_pkg::BK_SCALE) begin
			conf_q <= 16'((prod_q + 32'd32768) >> 16);
			w_q    <= {sqw_q, 2'b0} *
				dhbd_pkg::SZ_W'(dhbd_pkg::anchor_w(rec_q.scale, rec_q.anchor_slot));
			h_q    <= {sqh_q, 2'b0} *
				dhbd_pkg::SZ_W'(dhbd_pkg::anchor_h(rec_q.scale, rec_q.anchor_slot));
			// doubled centre in Q32: u * image size * 2048 * 2^scale
			cx2_q  <= ((DW'(ux_q) * DW'(dhbd_pkg::IMAGE_SIZE)) << 11) << rec_q.scale;
			cy2_q  <= ((DW'(uy_q) * DW'(dhbd_pkg::IMAGE_SIZE)) << 11) << rec_q.scale;
		end
		if (state_q == dhbd_pkg::BK_DIFF) begin
			pass_q <= (conf_q >= thr);
			dl_q   <= cx2_q - DW'(w_q);
			dt_q   <= cy2_q - DW'(h_q);
			wr_q   <= (w_round[dhbd_pkg::SZ_W:32] > 13'd2047) ? 11'd2047 : w_round[42:32];
			hr_q   <= (h_round[dhbd_pkg::SZ_W:32] > 13'd2047) ? 11'd2047 : h_round[42:32];
		end
	end

	always_comb begin
		rq_res.box_left   = round_corner(dl_q);
		rq_res.box_top    = round_corner(dt_q);
		rq_res.box_width  = wr_q;
		rq_res.box_height = hr_q;
		rq_res.confidence = conf_q;
		rq_res.class_id   = rec_q.class_id;
	end

endmodule

`default_nettype wire

@@ design/detection_head_box_decode.sv @@
// detection_head_box_decode: top level with configuration registers and queues
// depends on dhbd_pkg, dhbd_fifo, dhbd_front and dhbd_back
//
//   channel   handshake          payload
//   input     push / full        logit, scale, anchor_slot, grid_row, grid_col, last
//   result    empty / pop        box_left, box_top, box_width, box_height,
//                                confidence, class_id
//   config    cfg_valid/ready    cfg_index, cfg_data
//
// one logit beat per cycle while full is low; the sigmoid pipe is two stages deep
// a finished cell passes the back sequencer states MUL, SCALE, DIFF and EMIT
// (multipliers and rounding); a passing cell waits in EMIT for result queue room
// full rises only while a finished cell waits for room in the two-entry cell queue
// reset clears the cell state, the queues and the registers to their defaults
`timescale 1ns / 1ps
`default_nettype none

module detection_head_box_decode (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] logit,
	input  wire logic [1:0]         scale,
	input  wire logic [1:0]         anchor_slot,
	input  wire logic [5:0]         grid_row,
	input  wire logic [5:0]         grid_col,
	input  wire logic               last,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [11:0]      box_left,
	output logic signed [11:0]      box_top,
	output logic [10:0]             box_width,
	output logic [10:0]             box_height,
	output logic [15:0]             confidence,
	output logic [5:0]              class_id,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	localparam int REC_W = $bits(dhbd_pkg::cell_rec_t);
	localparam int RES_W = $bits(dhbd_pkg::res_t);

	logic [6:0]  num_classes_q;
	logic [15:0] thr_fine_q;
	logic [15:0] thr_mid_q;
	logic [15:0] thr_coarse_q;

	logic                cq_push;
	logic                cq_full;
	logic                cq_pop;
	logic                cq_empty;
	dhbd_pkg::cell_rec_t cq_wr_rec;
	logic [REC_W-1:0]    cq_rd_data;
	logic                rq_push;
	logic                rq_full;
	dhbd_pkg::res_t      rq_wr_res;
	logic [RES_W-1:0]    rq_rd_data;
	dhbd_pkg::res_t      rq_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= dhbd_pkg::RST_NUM_CLASSES;
			thr_fine_q    <= dhbd_pkg::RST_THRESHOLD_FINE;
			thr_mid_q     <= dhbd_pkg::RST_THRESHOLD_MID;
			thr_coarse_q  <= dhbd_pkg::RST_THRESHOLD_COARSE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dhbd_pkg::REG_NUM_CLASSES:      num_classes_q <= cfg_data[6:0];
				dhbd_pkg::REG_THRESHOLD_FINE:   thr_fine_q    <= cfg_data;
				dhbd_pkg::REG_THRESHOLD_MID:    thr_mid_q     <= cfg_data;
				dhbd_pkg::REG_THRESHOLD_COARSE: thr_coarse_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	dhbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.logit       (logit),
		.scale       (scale),
		.anchor_slot (anchor_slot),
		.grid_row    (grid_row),
		.grid_col    (grid_col),
		.last        (last),
		.num_classes (num_classes_q),
		.cq_full     (cq_full),
		.cq_push     (cq_push),
		.cq_rec      (cq_wr_rec)
	);

	dhbd_fifo #(
		.WIDTH (REC_W)
	) u_cell_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cq_push),
		.wr_data (cq_wr_rec),
		.full    (cq_full),
		.rd_en   (cq_pop),
		.rd_data (cq_rd_data),
		.empty   (cq_empty)
	);

	dhbd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cq_empty         (cq_empty),
		.cq_rec           (dhbd_pkg::cell_rec_t'(cq_rd_data)),
		.cq_pop           (cq_pop),
		.threshold_fine   (thr_fine_q),
		.threshold_mid    (thr_mid_q),
		.threshold_coarse (thr_coarse_q),
		.rq_full          (rq_full),
		.rq_push          (rq_push),
		.rq_res           (rq_wr_res)
	);

	dhbd_fifo #(
		.WIDTH (RES_W)
	) u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rq_push),
		.wr_data (rq_wr_res),
		.full    (rq_full),
		.rd_en   (pop),
		.rd_data (rq_rd_data),
		.empty   (empty)
	);

	assign rq_out     = dhbd_pkg::res_t'(rq_rd_data);
	assign box_left   = rq_out.box_left;
	assign box_top    = rq_out.box_top;
	assign box_width  = rq_out.box_width;
	assign box_height = rq_out.box_height;
	assign confidence = rq_out.confidence;
	assign class_id   = rq_out.class_id;

`ifndef ASSERT_OFF
	a_cell_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cq_push |-> !cq_full)
		else $error("cell queue written while full");

	a_cell_q_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> !cq_empty)
		else $error("cell queue read while empty");

	a_result_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rq_push |-> !rq_full)
		else $error("result queue written while full");

	a_stall_needs_cell: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> cq_full)
		else $error("input stalled with room in the cell queue");
`endif

endmodule

`default_nettype wire

@@ sim/tb_detection_head_box_decode.sv @@
// tb_detection_head_box_decode: self-checking bench for the detection head box decoder
// depends on dhbd_pkg and detection_head_box_decode; logit beats in, corner boxes checked
// against an in-bench fixed-point predictor, with random idling on both queue sides
`timescale 1ns / 1ps

module tb_detection_head_box_decode;

	localparam int              SETTLE_CYCLES = 24;
	localparam int              RANDOM_BEATS  = 220;
	localparam int              HOLD_CYCLES   = 300;
	localparam logic [95:0]     EXP_STEP      = 96'd4034748382;
	localparam logic [7:0]      REG_SPARE     = 8'd4;
	localparam logic [7:0]      REG_TOP       = 8'hFF;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic signed [15:0] logit = '0;
	logic [1:0]         scale = '0;
	logic [1:0]         anchor_slot = '0;
	logic [5:0]         grid_row = '0;
	logic [5:0]         grid_col = '0;
	logic               last = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [11:0] box_left;
	logic signed [11:0] box_top;
	logic [10:0]        box_width;
	logic [10:0]        box_height;
	logic [15:0]        confidence;
	logic [5:0]         class_id;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [7:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	// predictor state and register copies
	int         sig_lut [0:128];
	int         cell_pos;
	int         cell_sig [4];
	int         obj_p;
	int         best_p;
	logic [5:0] best_idx;
	int         cfg_classes;
	int         thr_fine;
	int         thr_mid;
	int         thr_coarse;
	int         anchor_dim [0:2][0:2][0:1] = '{
		'{'{10, 15}, '{13, 24}, '{18, 19}},
		'{'{20, 44}, '{29, 26}, '{42, 43}},
		'{'{64, 115}, '{139, 111}, '{309, 379}}
	};

	dhbd_pkg::res_t boxes_due [$];
	int   beat_count = 0;
	int   fault_count = 0;
	int   pop_hold = 0;
	bit   quiet = 1'b0;

	detection_head_box_decode uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.logit      (logit),
		.scale      (scale),
		.anchor_slot(anchor_slot),
		.grid_row   (grid_row),
		.grid_col   (grid_col),
		.last       (last),
		.empty      (empty),
		.pop        (pop),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_width  (box_width),
		.box_height (box_height),
		.confidence (confidence),
		.class_id   (class_id),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint round_off(input longint v, input int sh);
		longint half;
		half = longint'(1) << (sh - 1);
		if (v >= 0) begin
			return (v + half) >> sh;
		end
		return -((-v + half) >> sh);
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void clear_cell_state();
		cell_pos = 0;
		cell_sig = '{0, 0, 0, 0};
		obj_p = 0;
		best_p = 0;
		best_idx = '0;
	endfunction

	// advances the cell state by one beat and queues the box it completes, if any
	function automatic void decode_beat(input logic signed [15:0] lg, input logic [1:0] sc,
			input logic [1:0] sl, input logic [5:0] row, input logic [5:0] col,
			input logic lst);
		int     x;
		int     a;
		int     k;
		int     f;
		int     p;
		int     s;
		int     pos;
		int     lim;
		int     conf;
		int     thr;
		longint mul;
		longint cx;
		longint cy;
		longint w;
		longint h;
		dhbd_pkg::res_t r;
		x = lg;
		a = x < 0 ? -x : x;
		if (a >= 2048) begin
			p = sig_lut[128];
		end else begin
			k = a >> 4;
			f = a & 15;
			p = sig_lut[k] + (((sig_lut[k + 1] - sig_lut[k]) * f + 8) >> 4);
		end
		s = x < 0 ? 65536 - p : (p > 65535 ? 65535 : p);
		pos = cell_pos;
		lim = cfg_classes < dhbd_pkg::MAX_CLASSES ? cfg_classes : dhbd_pkg::MAX_CLASSES;
		if (pos < 4) begin
			cell_sig[pos] = s;
		end else if (pos == 4) begin
			obj_p = s;
		end else if (pos - 5 < lim && s > best_p) begin
			best_p = s;
			best_idx = 6'(pos - 5);
		end
		if (cell_pos < 127) begin
			cell_pos++;
		end
		if (!lst) begin
			return;
		end
		if (pos < 5 || sc > dhbd_pkg::SCALE_COARSE || sl >= dhbd_pkg::ANCHORS_PER_SCALE) begin
			clear_cell_state();
			return;
		end
		conf = int'((longint'(obj_p) * best_p + 32768) >> 16);
		case (sc)
			dhbd_pkg::SCALE_FINE: begin
				thr = thr_fine;
			end
			dhbd_pkg::SCALE_MID: begin
				thr = thr_mid;
			end
			default: begin
				thr = thr_coarse;
			end
		endcase
		if (conf < thr) begin
			clear_cell_state();
			return;
		end
		// centre and size terms in Q32
		mul = (longint'(dhbd_pkg::IMAGE_SIZE) << sc) * 1024;
		cx = (longint'(cell_sig[0]) * 2 - 32768 + longint'(col) * 65536) * mul;
		cy = (longint'(cell_sig[1]) * 2 - 32768 + longint'(row) * 65536) * mul;
		w = longint'(cell_sig[2]) * cell_sig[2] * 4 * anchor_dim[sc][sl][0];
		h = longint'(cell_sig[3]) * cell_sig[3] * 4 * anchor_dim[sc][sl][1];
		r.box_left = 12'(clamp(round_off(2 * cx - w, 33), -2048, 2047));
		r.box_top = 12'(clamp(round_off(2 * cy - h, 33), -2048, 2047));
		r.box_width = 11'(clamp(round_off(w, 32), 0, 2047));
		r.box_height = 11'(clamp(round_off(h, 32), 0, 2047));
		r.confidence = 16'(conf);
		r.class_id = best_idx;
		boxes_due = {boxes_due, r};
		clear_cell_state();
	endfunction

	function automatic logic signed [15:0] rand_logit();
		case ($urandom_range(0, 7))
			0: begin
				return 16'($urandom);
			end
			1: begin
				return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			end
			default: begin
				return 16'(int'($urandom_range(0, 4095)) - 2048);
			end
		endcase
	endfunction

	function automatic logic [15:0] rand_threshold();
		case ($urandom_range(0, 7))
			0: begin
				return 16'd0;
			end
			1: begin
				return 16'hFFFF;
			end
			2: begin
				return 16'($urandom);
			end
			default: begin
				return 16'($urandom_range(0, 24000));
			end
		endcase
	endfunction

	// receiver: random stall bursts, or a long hold-off when one is requested
	initial begin
		int gap_left;
		gap_left = 0;
		forever begin
			@(posedge clk);
			if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else if (gap_left > 0) begin
				pop <= 1'b0;
				gap_left--;
			end else begin
				pop <= 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0) begin
					gap_left = $urandom_range(1, 11);
				end
			end
		end
	end

	always @(posedge clk) begin
		dhbd_pkg::res_t want;
		if (arst_n && !empty && pop) begin
			if (boxes_due.size() == 0) begin
				if (fault_count < 10) begin
					$display("unexpected box: left %0d top %0d w %0d h %0d conf %0d class %0d",
						box_left, box_top, box_width, box_height, confidence, class_id);
				end
				fault_count++;
			end else begin
				want = boxes_due.pop_front();
				if (box_left !== want.box_left || box_top !== want.box_top ||
						box_width !== want.box_width || box_height !== want.box_height ||
						confidence !== want.confidence || class_id !== want.class_id) begin
					if (fault_count < 10) begin
						$display("box mismatch: expected %0d %0d %0d %0d conf %0d class %0d",
							want.box_left, want.box_top, want.box_width, want.box_height,
							want.confidence, want.class_id);
						$display("              got      %0d %0d %0d %0d conf %0d class %0d",
							box_left, box_top, box_width, box_height, confidence, class_id);
					end
					fault_count++;
				end
			end
		end
	end

	task automatic send_beat(input logic signed [15:0] lg, input logic [1:0] sc,
			input logic [1:0] sl, input logic [5:0] row, input logic [5:0] col,
			input logic lst);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		push <= 1'b1;
		logit <= lg;
		scale <= sc;
		anchor_slot <= sl;
		grid_row <= row;
		grid_col <= col;
		last <= lst;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		beat_count++;
		decode_beat(lg, sc, sl, row, col, lst);
	endtask

	// non-final beats carry random attributes; only the final beat's count
	task automatic send_cell(input logic signed [15:0] vals [$], input logic [1:0] sc,
			input logic [1:0] sl, input logic [5:0] row, input logic [5:0] col);
		for (int i = 0; i < vals.size(); i++) begin
			if (i == vals.size() - 1) begin
				send_beat(vals[i], sc, sl, row, col, 1'b1);
			end else begin
				send_beat(vals[i], 2'($urandom), 2'($urandom), 6'($urandom), 6'($urandom),
					1'b0);
			end
		end
	endtask

	task automatic random_cell();
		logic signed [15:0] vals [$];
		logic signed [15:0] v;
		logic [1:0]         sc;
		logic [1:0]         sl;
		int                 lim;
		int                 n;
		int                 hot;
		lim = cfg_classes < dhbd_pkg::MAX_CLASSES ? cfg_classes : dhbd_pkg::MAX_CLASSES;
		case ($urandom_range(0, 9))
			0: begin
				n = $urandom_range(1, 5);
			end
			1: begin
				n = $urandom_range(5, lim + 12);
			end
			default: begin
				n = 5 + (lim == 0 ? 1 : lim);
			end
		endcase
		hot = $urandom_range(5, n > 5 ? n - 1 : 5);
		for (int i = 0; i < n; i++) begin
			if (i == 4 && $urandom_range(0, 3) != 0) begin
				v = 16'($urandom_range(768, 32767));
			end else if (i == hot) begin
				v = 16'($urandom_range(512, 32767));
			end else begin
				v = rand_logit();
			end
			vals = {vals, v};
		end
		sc = $urandom_range(0, 11) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
		sl = $urandom_range(0, 11) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
		send_cell(vals, sc, sl, 6'($urandom), 6'($urandom));
	endtask

	// the back end may still be busy on a dropped cell once the queue is empty
	task automatic wait_idle();
		push <= 1'b0;
		while (boxes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			dhbd_pkg::REG_NUM_CLASSES: begin
				cfg_classes = data[6:0];
			end
			dhbd_pkg::REG_THRESHOLD_FINE: begin
				thr_fine = data;
			end
			dhbd_pkg::REG_THRESHOLD_MID: begin
				thr_mid = data;
			end
			dhbd_pkg::REG_THRESHOLD_COARSE: begin
				thr_coarse = data;
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_config(input logic [15:0] classes_word, input logic [15:0] tf,
			input logic [15:0] tm, input logic [15:0] tc);
		wait_idle();
		write_reg(dhbd_pkg::REG_NUM_CLASSES, classes_word);
		write_reg(dhbd_pkg::REG_THRESHOLD_FINE, tf);
		write_reg(dhbd_pkg::REG_THRESHOLD_MID, tm);
		write_reg(dhbd_pkg::REG_THRESHOLD_COARSE, tc);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		logic signed [15:0] vals [$];
		vals = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF};
		// two equal maxima, the earlier must win
		for (int i = 0; i < 36; i++) begin
			vals = {vals, ((i == 7 || i == 20) ? 16'sh7FFF : 16'(-300 - i))};
		end
		send_cell(vals, dhbd_pkg::SCALE_FINE, 2'd1, 6'd10, 6'd20);
	endtask

	task automatic test_registers();
		logic signed [15:0] vals [$];
		wait_idle();
		write_reg(dhbd_pkg::REG_NUM_CLASSES, 16'hFF83);
		write_reg(dhbd_pkg::REG_THRESHOLD_FINE, 16'd0);
		write_reg(dhbd_pkg::REG_THRESHOLD_MID, 16'd0);
		write_reg(dhbd_pkg::REG_THRESHOLD_COARSE, 16'd0);
		// spare indexes alias the real ones if the decode drops upper bits
		write_reg(REG_SPARE, 16'h0040);
		write_reg(REG_TOP, 16'hFFFF);
		cfg_valid <= 1'b0;
		vals = '{16'sh8000, 16'sh7FFF, 16'sd2048, -16'sd2048, 16'sd2047, -16'sd1, 16'sd1,
			-16'sd2047};
		send_cell(vals, dhbd_pkg::SCALE_FINE, 2'd0, 6'd0, 6'd0);
		// classes past the limit must not take part in the argmax
		vals = '{16'sd16, -16'sd16, 16'sd255, -16'sd255, 16'sh7FFF, 16'sd100, 16'sd200,
			16'sd300, 16'sh7FFF, 16'sh7FFF};
		send_cell(vals, dhbd_pkg::SCALE_MID, 2'd2, 6'd63, 6'd63);
		// far corner of the coarse grid saturates left and top
		vals = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sd0,
			16'sd0};
		send_cell(vals, dhbd_pkg::SCALE_COARSE, 2'd2, 6'd63, 6'd63);
		vals = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd512,
			16'sd9};
		send_cell(vals, dhbd_pkg::SCALE_COARSE, 2'd2, 6'd0, 6'd0);
	endtask

	task automatic test_special_cells();
		logic signed [15:0] vals [$];
		set_config(16'd3, 16'd0, 16'd0, 16'd0);
		vals = '{16'sd100};
		send_cell(vals, dhbd_pkg::SCALE_FINE, 2'd0, 6'd1, 6'd1);
		vals = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5};
		send_cell(vals, dhbd_pkg::SCALE_MID, 2'd1, 6'd2, 6'd2);
		vals = '{16'sd10, 16'sd20, 16'sd30, 16'sd40, 16'sd5000, 16'sd600, 16'sd700, 16'sd800};
		send_cell(vals, 2'd3, 2'd0, 6'd3, 6'd3);
		send_cell(vals, dhbd_pkg::SCALE_MID, 2'd3, 6'd4, 6'd4);
		send_cell(vals, dhbd_pkg::SCALE_MID, 2'd0, 6'd5, 6'd5);
		// no class logit counts: class 0 and zero confidence
		set_config(16'd0, 16'd0, 16'd0, 16'd0);
		send_cell(vals, dhbd_pkg::SCALE_FINE, 2'd2, 6'd6, 6'd6);
		// only the mid scale threshold can be met
		set_config(16'd2, 16'hFFFF, 16'd0, 16'hFFFF);
		vals = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
		send_cell(vals, dhbd_pkg::SCALE_FINE, 2'd0, 6'd7, 6'd7);
		send_cell(vals, dhbd_pkg::SCALE_MID, 2'd0, 6'd7, 6'd7);
		send_cell(vals, dhbd_pkg::SCALE_COARSE, 2'd0, 6'd7, 6'd7);
	endtask

	task automatic test_long_cell();
		logic signed [15:0] vals [$];
		set_config(16'd127, 16'd0, 16'd0, 16'd0);
		vals = '{16'sd64, -16'sd64, 16'sd128, -16'sd128, 16'sh7FFF};
		// the larger logit sits past the 64-class ceiling, the position counter saturates
		for (int i = 0; i < 135; i++) begin
			vals = {vals, (i == 63 ? 16'sd20000 : (i == 70 ? 16'sh7FFF : 16'(-100 - i)))};
		end
		send_cell(vals, dhbd_pkg::SCALE_MID, 2'd1, 6'd31, 6'd17);
	endtask

	task automatic test_backpressure();
		set_config(16'd1, 16'd0, 16'd0, 16'd0);
		pop_hold = HOLD_CYCLES;
		repeat (25) random_cell();
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int first_beat;
		int nc;
		int batch;
		first_beat = beat_count;
		while (beat_count - first_beat < RANDOM_BEATS) begin
			case ($urandom_range(0, 9))
				0: begin
					nc = 0;
				end
				1: begin
					nc = 64;
				end
				2: begin
					nc = 127;
				end
				3: begin
					nc = $urandom_range(7, 127);
				end
				default: begin
					nc = $urandom_range(1, 6);
				end
			endcase
			set_config({9'($urandom), 7'(nc)}, rand_threshold(), rand_threshold(),
				rand_threshold());
			batch = $urandom_range(6, 16);
			for (int j = 0; j < batch && beat_count - first_beat < RANDOM_BEATS; j++) begin
				random_cell();
			end
		end
	endtask

	task automatic test_steady_stream();
		set_config(16'd4, 16'd2000, 16'd1000, 16'd0);
		quiet = 1'b1;
		repeat (12) random_cell();
	endtask

	initial begin
		logic [95:0] e;
		logic [95:0] d;
		// sigmoid(i/16) in Q0.16, exponent stepped down by exp(-1/16)
		e = 96'd1 << 32;
		for (int i = 0; i <= 128; i++) begin
			d = (96'd1 << 32) + e;
			sig_lut[i] = int'(((96'd1 << 48) + (d >> 1)) / d);
			e = (e * EXP_STEP + (96'd1 << 31)) >> 32;
		end
		clear_cell_state();
		cfg_classes = dhbd_pkg::RST_NUM_CLASSES;
		thr_fine = dhbd_pkg::RST_THRESHOLD_FINE;
		thr_mid = dhbd_pkg::RST_THRESHOLD_MID;
		thr_coarse = dhbd_pkg::RST_THRESHOLD_COARSE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_registers();
		test_special_cells();
		test_long_cell();
		test_backpressure();
		test_random_traffic();
		test_steady_stream();
		wait_idle();
		if (fault_count == 0 && boxes_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
